### rtl/aacs_pkg.sv
// Package for the antialiased circle pixel shader: config/side structs,
// register index codes, fixed-point constants and ARGB channel helpers.
// No dependencies.
`default_nettype none

package aacs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int COV_SHIFT = FRAC_BITS - 8;

  // sqrt(2) bound as a ratio: r2 = floor(r1 * SQRT2_NUM / SQRT2_DEN)
  localparam logic [27:0] SQRT2_NUM = 28'd141421357;
  localparam logic [26:0] SQRT2_DEN = 27'd100000000;

  localparam logic [31:0] WHITE = 32'hffff_ffff;

  localparam int SQRT_STAGES = 32;
  localparam int FRONT_STAGES = 5;
  localparam int BLEND_STAGES = 3;
  localparam int LATENCY = FRONT_STAGES + SQRT_STAGES + BLEND_STAGES;

  localparam logic [2:0] REG_OUTER_R = 3'd0;
  localparam logic [2:0] REG_INNER_R = 3'd1;
  localparam logic [2:0] REG_STROKE  = 3'd2;
  localparam logic [2:0] REG_FILL    = 3'd3;
  localparam logic [2:0] REG_MODE    = 3'd4;
  localparam logic [2:0] REG_INNER   = 3'd5;
  localparam logic [2:0] REG_SRC     = 3'd6;

  localparam logic [1:0] MODE_STROKE = 2'd0;
  localparam logic [1:0] MODE_FILL   = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;

  typedef struct packed {
    logic [29:0] outer_r;
    logic [29:0] inner_r;
    logic [31:0] stroke_color;
    logic [31:0] fill_color;
    logic [1:0]  mode;
    logic        inner_enable;
    logic        fill_source_present;
  } cfg_t;

  typedef struct packed {
    logic [31:0] op_pre;
    logic [31:0] p_pre;
    logic        in_box;
    logic        inner_apply;
    logic        lt_o;
    logic        gt_o;
    logic        lt_i;
    logic        gt_i;
  } side_t;

  function automatic logic [31:0] mul4_sym(logic [31:0] p, logic [31:0] q);
    logic [31:0] r;
    logic [15:0] t;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      t = {8'd0, p[8*i +: 8]} * {8'd0, q[8*i +: 8]} + 16'd255;
      r[8*i +: 8] = t[15:8];
    end
    return r;
  endfunction

  function automatic logic [31:0] mul256(logic [8:0] k, logic [31:0] c);
    logic [31:0] r;
    logic [16:0] t;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      t = {9'd0, c[8*i +: 8]} * {8'd0, k};
      r[8*i +: 8] = t[15:8];
    end
    return r;
  endfunction

  function automatic logic [31:0] interp256(logic [8:0] k, logic [31:0] p, logic [31:0] q);
    logic [31:0] r;
    logic [16:0] t;
    logic [8:0]  kc;
    r = '0;
    kc = 9'd256 - k;
    for (int i = 0; i < 4; i++) begin
      t = {9'd0, p[8*i +: 8]} * {8'd0, k} + {9'd0, q[8*i +: 8]} * {8'd0, kc};
      r[8*i +: 8] = t[15:8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/aacs_front.sv
// Front end: abs, squares, box and diamond tests, pre-blend colors.
// Five register stages. Depends on aacs_pkg.
`default_nettype none

module aacs_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire aacs_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  input  wire logic [31:0]      pos_x,
  input  wire logic [31:0]      pos_y,
  input  wire logic [31:0]      under_pixel,
  output logic                  out_valid,
  output logic [63:0]           dsq,
  output aacs_pkg::side_t       side
);

  // F0
  logic        v0;
  logic [31:0] px0, py0, u0;
  // F1
  logic        v1;
  logic [31:0] ax1, ay1, u1;
  // F2
  logic        v2;
  logic [63:0] sqx2, sqy2;
  logic [32:0] sum2;
  aacs_pkg::side_t s2;
  // F3
  logic        v3;
  logic [63:0] dsq3;
  logic [43:0] lhs_lo3, ro_lo3, ri_lo3;
  logic [42:0] lhs_hi3, ro_hi3, ri_hi3;
  aacs_pkg::side_t s3;
  // F4
  logic        v4;
  logic [63:0] dsq4;
  aacs_pkg::side_t s4;

  logic [30:0] r1o, r1i;
  logic        fill_sel, src, inner;
  logic [31:0] ocol, icol;
  logic [59:0] lhs, rho, rhi;

  always_comb begin
    r1o = {1'b0, cfg.outer_r} + 31'(aacs_pkg::ONE);
    r1i = {1'b0, cfg.inner_r} + 31'(aacs_pkg::ONE);
    fill_sel = (cfg.mode == aacs_pkg::MODE_FILL);
    src = cfg.fill_source_present && (cfg.mode != aacs_pkg::MODE_STROKE);
    inner = cfg.inner_enable && !fill_sel;
    icol = (cfg.mode == aacs_pkg::MODE_STROKE) ? 32'd0 : cfg.fill_color;
    ocol = fill_sel ? cfg.fill_color : cfg.stroke_color;
    // diamond test as sum*DEN > r1*NUM, no divide
    lhs = {16'd0, lhs_lo3} + {lhs_hi3, 17'd0};
    rho = {16'd0, ro_lo3} + {1'b0, ro_hi3, 16'd0};
    rhi = {16'd0, ri_lo3} + {1'b0, ri_hi3, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    px0 <= pos_x;
    py0 <= pos_y;
    u0  <= under_pixel;

    ax1 <= px0[31] ? 32'(-px0) : px0;
    ay1 <= py0[31] ? 32'(-py0) : py0;
    u1  <= u0;

    sqx2 <= {32'd0, ax1} * {32'd0, ax1};
    sqy2 <= {32'd0, ay1} * {32'd0, ay1};
    sum2 <= {1'b0, ax1} + {1'b0, ay1};
    s2.in_box <= ({1'b0, ax1} <= {2'b0, r1o}) && ({1'b0, ay1} <= {2'b0, r1o});
    s2.inner_apply <= inner && ({1'b0, ax1} <= {2'b0, r1i}) && ({1'b0, ay1} <= {2'b0, r1i});
    s2.op_pre <= (fill_sel && src) ? aacs_pkg::mul4_sym(u1, ocol) : ocol;
    if (src) begin
      s2.p_pre <= (icol == aacs_pkg::WHITE) ? u1 : aacs_pkg::mul4_sym(icol, u1);
    end else begin
      s2.p_pre <= icol;
    end
    s2.lt_o <= 1'b0;
    s2.gt_o <= 1'b0;
    s2.lt_i <= 1'b0;
    s2.gt_i <= 1'b0;

    dsq3    <= sqx2 + sqy2;
    lhs_lo3 <= {27'd0, sum2[16:0]} * {17'd0, aacs_pkg::SQRT2_DEN};
    lhs_hi3 <= {27'd0, sum2[32:17]} * {16'd0, aacs_pkg::SQRT2_DEN};
    ro_lo3  <= {28'd0, r1o[15:0]} * {16'd0, aacs_pkg::SQRT2_NUM};
    ro_hi3  <= {28'd0, r1o[30:16]} * {15'd0, aacs_pkg::SQRT2_NUM};
    ri_lo3  <= {28'd0, r1i[15:0]} * {16'd0, aacs_pkg::SQRT2_NUM};
    ri_hi3  <= {28'd0, r1i[30:16]} * {15'd0, aacs_pkg::SQRT2_NUM};
    s3      <= {s2.op_pre, s2.p_pre, s2.in_box, s2.inner_apply,
                sum2 < {3'b0, cfg.outer_r}, s2.gt_o,
                sum2 < {3'b0, cfg.inner_r}, s2.gt_i};

    dsq4    <= dsq3;
    s4      <= {s3.op_pre, s3.p_pre, s3.in_box, s3.inner_apply,
                s3.lt_o, lhs > rho, s3.lt_i, lhs > rhi};
  end

  assign out_valid = v4;
  assign dsq = dsq4;
  assign side = s4;

  // r2 >= r0, so a word can never be both inside and beyond the outer diamond
  a_diamond_order: assert property (@(posedge clk) disable iff (rst)
    v4 |-> !(s4.lt_o && s4.gt_o))
    else $error("outer diamond flags conflict");

endmodule

`default_nettype wire

### rtl/aacs_isqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage,
// carrying the side word along. Depends on aacs_pkg.
`default_nettype none

module aacs_isqrt (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [63:0]     radicand,
  input  wire aacs_pkg::side_t in_side,
  output logic                 out_valid,
  output logic [31:0]          root,
  output aacs_pkg::side_t      out_side
);

  localparam int N = aacs_pkg::SQRT_STAGES;

  logic            val_q  [1:N];
  logic [33:0]     rem_q  [1:N];
  logic [31:0]     root_q [1:N];
  logic [63:0]     rad_q  [1:N];
  aacs_pkg::side_t side_q [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic            vi;
    logic [33:0]     ri;
    logic [31:0]     qi;
    logic [63:0]     di;
    aacs_pkg::side_t si;
    logic [34:0]     rem_sh, trial, diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign ri = '0;
      assign qi = '0;
      assign di = radicand;
      assign si = in_side;
    end else begin : g_next
      assign vi = val_q[i];
      assign ri = rem_q[i];
      assign qi = root_q[i];
      assign di = rad_q[i];
      assign si = side_q[i];
    end

    always_comb begin
      rem_sh = {ri[32:0], di[63:62]};
      trial  = {1'b0, qi, 2'b01};
      diff   = rem_sh - trial;
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[i+1] <= 1'b0;
      end else begin
        val_q[i+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[i+1]  <= ge ? diff[33:0] : rem_sh[33:0];
      root_q[i+1] <= {qi[30:0], ge};
      rad_q[i+1]  <= {di[61:0], 2'b00};
      side_q[i+1] <= si;
    end
  end

  assign out_valid = val_q[N];
  assign root = root_q[N];
  assign out_side = side_q[N];

  // remainder of a floor root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    val_q[N] |-> ({1'b0, rem_q[N]} <= {2'b0, root_q[N], 1'b0}))
    else $error("sqrt remainder out of range");

endmodule

`default_nettype wire

### rtl/aacs_blend.sv
// Coverage from distance and diamond flags, then stroke scaling and
// inner blend. Three register stages. Depends on aacs_pkg.
`default_nettype none

module aacs_blend (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire aacs_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  input  wire logic [31:0]     root_in,
  input  wire aacs_pkg::side_t side,
  output logic                 out_valid,
  output logic [31:0]          pixel
);

  function automatic logic [8:0] cov(logic lt, logic gt, logic [31:0] d, logic [29:0] r0);
    logic [30:0] r1;
    logic [31:0] dd, sh;
    logic [8:0]  k;
    r1 = {1'b0, r0} + 31'(aacs_pkg::ONE);
    dd = d - {2'b0, r0};
    sh = dd >> aacs_pkg::COV_SHIFT;
    if (lt) begin
      k = 9'd256;
    end else if (gt) begin
      k = 9'd0;
    end else if (d < {1'b0, r1}) begin
      k = (d > {2'b0, r0}) ? (9'd256 - {1'b0, sh[7:0]}) : 9'd256;
    end else begin
      k = 9'd0;
    end
    return k;
  endfunction

  logic        v1, v2, v3;
  logic [8:0]  ko1, ki1, ki2;
  logic [31:0] op1, pp1, opk2, pp2, pix3;
  logic        box1, ia1, box2, ia2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ko1  <= cov(side.lt_o, side.gt_o, root_in, cfg.outer_r);
    ki1  <= cov(side.lt_i, side.gt_i, root_in, cfg.inner_r);
    op1  <= side.op_pre;
    pp1  <= side.p_pre;
    box1 <= side.in_box;
    ia1  <= side.inner_apply;

    opk2 <= aacs_pkg::mul256(ko1, op1);
    pp2  <= pp1;
    ki2  <= ki1;
    box2 <= box1;
    ia2  <= ia1;

    if (!box2) begin
      pix3 <= '0;
    end else if (ia2) begin
      pix3 <= aacs_pkg::interp256(ki2, pp2, opk2);
    end else begin
      pix3 <= opk2;
    end
  end

  assign out_valid = v3;
  assign pixel = pix3;

  // zero outer coverage with no interior must come out transparent black
  a_zero_cov: assert property (@(posedge clk) disable iff (rst)
    (v1 && ko1 == 9'd0 && !ia1) |-> ##2 (pixel == 32'd0))
    else $error("zero coverage gave nonzero pixel");

endmodule

`default_nettype wire

### rtl/aa_circle_pixel_shader.sv
// Antialiased circle pixel shader, top level: config registers and pipeline.
// Depends on aacs_pkg, aacs_front, aacs_isqrt, aacs_blend.
//
// Input channel: pos_x, pos_y (signed 16.16, relative to the centre) and
// under_pixel (ARGB8888 from the fill source) are taken at each rising edge
// with start high and busy low. busy stays low, so one pixel can enter every
// clock.
// Result channel: pixel_out is shown for one cycle with done high, once its
// word has passed 5 front stages (abs, squares, diamond products), 32 stages
// of the bit-per-stage square root and 3 blend stages.
// Throughput is one pixel per clock; results leave in input order. The
// receiver has no backpressure and must take every word.
// Config channel: cfg_index / cfg_data with cfg_valid and cfg_ready;
// cfg_ready is always high. Index 0 outer radius, 1 inner radius, 2 stroke
// color, 3 fill color, 4 draw mode, 5 inner enable, 6 fill source present.
// Write registers only while no pixel is in flight.
// Reset (rst, synchronous): clears the pipeline valids and the registers to
// zero, draw mode to stroke-and-fill.
`default_nettype none

module aa_circle_pixel_shader (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] under_pixel,
  output logic             done,
  output logic [31:0]      pixel_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  aacs_pkg::cfg_t  cfg;
  aacs_pkg::side_t f_side, s_side;
  logic            f_valid, s_valid;
  logic [63:0]     f_dsq;
  logic [31:0]     s_root;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outer_r             <= '0;
      cfg.inner_r             <= '0;
      cfg.stroke_color        <= '0;
      cfg.fill_color          <= '0;
      cfg.mode                <= aacs_pkg::MODE_BOTH;
      cfg.inner_enable        <= 1'b0;
      cfg.fill_source_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aacs_pkg::REG_OUTER_R: cfg.outer_r             <= cfg_data[29:0];
        aacs_pkg::REG_INNER_R: cfg.inner_r             <= cfg_data[29:0];
        aacs_pkg::REG_STROKE:  cfg.stroke_color        <= cfg_data;
        aacs_pkg::REG_FILL:    cfg.fill_color          <= cfg_data;
        aacs_pkg::REG_MODE:    cfg.mode                <= cfg_data[1:0];
        aacs_pkg::REG_INNER:   cfg.inner_enable        <= cfg_data[0];
        aacs_pkg::REG_SRC:     cfg.fill_source_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aacs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (start && !busy),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .under_pixel (under_pixel),
    .out_valid   (f_valid),
    .dsq         (f_dsq),
    .side        (f_side)
  );

  aacs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .radicand  (f_dsq),
    .in_side   (f_side),
    .out_valid (s_valid),
    .root      (s_root),
    .out_side  (s_side)
  );

  aacs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_valid),
    .root_in   (s_root),
    .side      (s_side),
    .out_valid (done),
    .pixel     (pixel_out)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, aacs_pkg::LATENCY))
    else $error("result word without matching input word");

endmodule

`default_nettype wire

### tb/aacs_checker.sv
// Checker for the antialiased circle pixel shader: shadows the config
// registers, predicts each output pixel and compares it with pixel_out.
// Depends on aacs_pkg for register index and draw mode codes.
module aacs_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] under_pixel,
  input  logic        done,
  input  logic [31:0] pixel_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [29:0] outer_r, inner_r;
  logic [31:0] stroke_c, fill_c;
  logic [1:0]  mode;
  logic        inner_en, src_en;
  logic [31:0] pixel_q[$];

  function automatic logic [31:0] chan_mul(logic [31:0] p, logic [31:0] q);
    logic [31:0] r;
    r = '0;
    for (int s = 0; s < 32; s += 8)
      r[s +: 8] = 8'((32'(p[s +: 8]) * 32'(q[s +: 8]) + 255) >> 8);
    return r;
  endfunction

  function automatic logic [31:0] chan_scale(int k, logic [31:0] c);
    logic [31:0] r;
    r = '0;
    for (int s = 0; s < 32; s += 8)
      r[s +: 8] = 8'((32'(c[s +: 8]) * k) >> 8);
    return r;
  endfunction

  function automatic logic [31:0] chan_lerp(int k, logic [31:0] p, logic [31:0] q);
    logic [31:0] r;
    r = '0;
    for (int s = 0; s < 32; s += 8)
      r[s +: 8] = 8'((32'(p[s +: 8]) * k + 32'(q[s +: 8]) * (256 - k)) >> 8);
    return r;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int disc_cover(longint unsigned sum, longint unsigned dsq,
                                    longint unsigned r0);
    longint unsigned r1, r2, d;
    int k;
    r1 = r0 + 65536;
    r2 = (r1 * 64'd141421357) / 64'd100000000;
    k = 256;
    if (sum >= r0) begin
      k = 0;
      if (sum <= r2) begin
        d = root_floor(dsq);
        if (d < r1) begin
          k = 256;
          if (d > r0) k -= int'((d - r0) >> 8);
        end
      end
    end
    return k;
  endfunction

  function automatic logic [31:0] shade(logic [31:0] px, logic [31:0] py,
                                        logic [31:0] under);
    longint x, y;
    longint unsigned ax, ay, sum, dsq, or1, ir1;
    logic [31:0] ocol, icol, op, p;
    logic src, inn, fonly;
    int k;
    x = longint'($signed(px));
    y = longint'($signed(py));
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    sum = ax + ay;
    dsq = ax * ax + ay * ay;
    or1 = longint'(outer_r) + 65536;
    ir1 = longint'(inner_r) + 65536;
    ocol = stroke_c;
    icol = fill_c;
    src = src_en;
    inn = inner_en;
    fonly = 0;
    if (mode == aacs_pkg::MODE_STROKE) begin
      icol = 0;
      src = 0;
    end else if (mode == aacs_pkg::MODE_FILL) begin
      ocol = icol;
      fonly = 1;
      inn = 0;
    end
    if (!(ax <= or1 && ay <= or1)) return 32'd0;
    op = ocol;
    if (fonly && src) op = chan_mul(under, op);
    k = disc_cover(sum, dsq, outer_r);
    if (k < 256) op = chan_scale(k, op);
    p = op;
    if (inn && ax <= ir1 && ay <= ir1) begin
      p = icol;
      if (src) begin
        p = under;
        if (icol != aacs_pkg::WHITE) p = chan_mul(icol, p);
      end
      k = disc_cover(sum, dsq, inner_r);
      if (k < 256) p = chan_lerp(k, p, op);
    end
    return p;
  endfunction

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    if (rst) begin
      outer_r <= '0; inner_r <= '0; stroke_c <= '0; fill_c <= '0;
      mode <= aacs_pkg::MODE_BOTH; inner_en <= 0; src_en <= 0;
      fail_count <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aacs_pkg::REG_OUTER_R: outer_r <= cfg_data[29:0];
          aacs_pkg::REG_INNER_R: inner_r <= cfg_data[29:0];
          aacs_pkg::REG_STROKE:  stroke_c <= cfg_data;
          aacs_pkg::REG_FILL:    fill_c <= cfg_data;
          aacs_pkg::REG_MODE:    mode <= cfg_data[1:0];
          aacs_pkg::REG_INNER:   inner_en <= cfg_data[0];
          aacs_pkg::REG_SRC:     src_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) pixel_q.push_back(shade(pos_x, pos_y, under_pixel));
      if (done) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected word pixel_out=%h", $time, pixel_out);
          fail_count <= fail_count + 1;
        end else begin
          if (pixel_q[0] !== pixel_out) begin
            $display("%0t: pixel_out expected %h actual %h", $time, pixel_q[0],
                     pixel_out);
            fail_count <= fail_count + 1;
          end
          void'(pixel_q.pop_front());
        end
      end
    end
  end
endmodule

### tb/tb_aa_circle_pixel_shader.sv
// Testbench top for the antialiased circle pixel shader: clock, reset,
// config writes and pixel stimulus; verdict from aacs_checker's fail count.
// Depends on aacs_pkg, aacs_checker and the RTL.
module tb_aa_circle_pixel_shader;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1, start = 0, cfg_valid = 0;
  logic [31:0] pos_x = 0, pos_y = 0, under_pixel = 0, cfg_data = 0;
  logic [2:0] cfg_index = aacs_pkg::REG_OUTER_R;
  logic busy, done, cfg_ready;
  logic [31:0] pixel_out;
  int fail_count, pending, idle_pct;
  int cycles = 0;
  logic [29:0] cur_r;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  aa_circle_pixel_shader u_top (.*);

  aacs_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // let the pipe drain fully before touching registers
  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (aacs_pkg::LATENCY + 4) @(posedge clk);
  endtask

  // start stays high after the word is taken; the next idle cycle or drain drops it
  task automatic send_pixel(logic [31:0] x, logic [31:0] y, logic [31:0] u);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    pos_x <= x;
    pos_y <= y;
    under_pixel <= u;
    start <= 1;
    do @(posedge clk); while (busy);
  endtask

  // coordinates mostly between zero and 3.0 beyond the current outer radius
  function automatic logic [31:0] near_coord();
    longint v;
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: begin
        v = longint'($urandom_range(32'(cur_r) + 32'h30000));
        if ($urandom_range(1)) v = -v;
        return 32'(v);
      end
    endcase
  endfunction

  task automatic configure(logic [29:0] ro, logic [29:0] ri, logic [1:0] m,
                           logic ie, logic sp, logic [31:0] sc, logic [31:0] fc);
    drain();
    cur_r = ro;
    write_reg(aacs_pkg::REG_OUTER_R, 32'(ro));
    write_reg(aacs_pkg::REG_INNER_R, 32'(ri));
    write_reg(aacs_pkg::REG_STROKE, sc);
    write_reg(aacs_pkg::REG_FILL, fc);
    write_reg(aacs_pkg::REG_MODE, 32'(m));
    write_reg(aacs_pkg::REG_INNER, 32'(ie));
    write_reg(aacs_pkg::REG_SRC, 32'(sp));
    cfg_valid <= 0;
  endtask

  initial begin
    logic [29:0] ro;
    idle_pct = 0;
    cur_r = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset config, then extremes and every draw mode
    send_pixel(0, 0, 32'hffff_ffff);
    configure(30'h50000, 30'h20000, aacs_pkg::MODE_BOTH, 1'b1, 1'b1,
              32'hff80_4020, 32'h80ff_00ff);
    send_pixel(0, 0, 32'h1234_5678);
    send_pixel(32'h48000, 0, 32'hffff_ffff);
    send_pixel(32'h38000, 32'hfffc_8000, 32'h0);
    send_pixel(32'h40000, 32'h40000, 32'hffff_ffff);
    send_pixel(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    send_pixel(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_pixel(32'h28000, 32'h0, 32'haaaa_5555);
    configure(30'h50000, 30'h20000, aacs_pkg::MODE_BOTH, 1'b1, 1'b1,
              32'hff80_4020, aacs_pkg::WHITE);
    send_pixel(32'h10000, 0, 32'h5555_aaaa);
    send_pixel(32'h28000, 32'h1000, 32'h5555_aaaa);
    configure(30'h3fff_ffff, 30'h3fff_ffff, aacs_pkg::MODE_STROKE, 1'b1, 1'b1,
              32'hffff_ffff, aacs_pkg::WHITE);
    send_pixel(32'h7fff_ffff, 0, 32'hffff_ffff);
    send_pixel(32'h4000_8000, 32'h0, 32'hffff_ffff);
    send_pixel(32'h2d41_3cd0, 32'h2d41_3cd0, 32'hffff_ffff);
    configure(30'h0, 30'h0, aacs_pkg::MODE_FILL, 1'b1, 1'b1,
              32'h1122_3344, 32'hffee_ddcc);
    send_pixel(0, 0, 32'hffff_ffff);
    send_pixel(32'h8000, 32'h8000, 32'h8080_8080);
    send_pixel(32'h10000, 32'h10000, 32'h8080_8080);
    // unused mode code behaves as stroke and fill
    configure(30'h30000, 30'h10000, 2'd3, 1'b1, 1'b0, 32'hffff_ffff, 32'h0);
    send_pixel(32'h20000, 32'h8000, 32'hffff_ffff);
    send_pixel(32'h8000, 0, 32'hffff_ffff);
    // random phases: 8 settings x 250 pixels, varying idle rate
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(9))
        0: ro = 30'($urandom);
        1: ro = 0;
        default: ro = 30'($urandom_range(32'h80_0000));
      endcase
      configure(ro, $urandom_range(1) ? 30'($urandom_range(32'(ro))) : 30'($urandom),
                2'($urandom), 1'($urandom), 1'($urandom),
                $urandom_range(3) ? $urandom : aacs_pkg::WHITE,
                $urandom_range(3) ? $urandom : aacs_pkg::WHITE);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 56;
        default: idle_pct = 36;
      endcase
      for (int i = 0; i < 250; i++)
        send_pixel(near_coord(), near_coord(),
                   $urandom_range(4) ? $urandom : 32'hffff_ffff);
    end
    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
